>>> rtl/ell_pkg.sv
// ----------------------------------------------------------------------------
// ell_pkg
// Shared types and constants for the echo loop with dynamic limiter.
// ----------------------------------------------------------------------------
package ell_pkg;

  // request function codes
  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_TICK   = 2'd1,
    FN_ARM    = 2'd2,
    FN_NONE   = 2'd3
  } ell_func_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_LENGTH       = 3'd0,
    REG_ECHO_GAIN         = 3'd1,
    REG_LIMITER_THRESHOLD = 3'd2,
    REG_LIMITER_DECAY     = 3'd3,
    REG_LIMITER_RECOVER   = 3'd4,
    REG_LIMITER_CEILING   = 3'd5
  } ell_reg_t;

  typedef struct packed {
    ell_func_t          func;
    logic signed [15:0] sample_in;
    logic [15:0]        skip_count;
    logic [14:0]        skip_start;
  } ell_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [15:0]        gain_now;
  } ell_out_t;

  typedef struct packed {
    logic [15:0] loop_length;
    logic [8:0]  echo_gain;
    logic [14:0] limiter_threshold;
    logic [15:0] limiter_decay;
    logic [15:0] limiter_recover;
    logic [15:0] limiter_ceiling;
  } ell_cfg_t;

  localparam logic [15:0] RST_LOOP_LENGTH       = 16'd0;
  localparam logic [8:0]  RST_ECHO_GAIN         = 9'd128;
  localparam logic [14:0] RST_LIMITER_THRESHOLD = 15'd30000;
  localparam logic [15:0] RST_LIMITER_DECAY     = 16'd64880;
  localparam logic [15:0] RST_LIMITER_RECOVER   = 16'd16538;
  localparam logic [15:0] RST_LIMITER_CEILING   = 16'd16384;
  localparam logic [15:0] RST_LIMITER_GAIN      = 16'd16384;

  // gain must be at least this (0.01 in Q2.14) for decay to apply
  localparam logic [15:0] GAIN_FLOOR = 16'd164;

  // datapath widths: sum at scale 2^8, product at scale 2^22
  localparam int SUM_W      = 26;
  localparam int PROD_W     = 43;
  localparam int FRAC_SHIFT = 22;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_MUL,
    ST_LIMIT,
    ST_TICK,
    ST_DONE
  } ell_state_t;

  typedef struct packed {
    logic take;     // latch request
    logic step;     // advance ring positions and skip run
    logic arm;      // load skip run
    logic clr_wr;   // clearing pass write
    logic zero_wr;  // skip-run zero write at read position
    logic mac;      // echo multiply-accumulate
    logic mul;      // limiter gain multiply
    logic lim;      // limit, saturate, write back
    logic tick;     // recovery multiply
    logic emit;     // update gain, load result register
  } ell_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } ell_stat_t;

endpackage

>>> rtl/ell_ram.sv
// ----------------------------------------------------------------------------
// ell_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ell_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ell_ctrl.sv
// ----------------------------------------------------------------------------
// ell_ctrl
// Sequencer: clearing pass after reset, then one request at a time.
// ----------------------------------------------------------------------------
module ell_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  ell_pkg::ell_func_t  req_func,
  output logic                req_stall,
  input  ell_pkg::ell_stat_t  stat,
  output ell_pkg::ell_cmd_t   cmd
);

  ell_pkg::ell_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ell_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      ell_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = ell_pkg::ST_IDLE;
        end
      end
      ell_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.take = 1'b1;
          unique case (req_func)
            ell_pkg::FN_SAMPLE: begin
              cmd.step   = 1'b1;
              state_next = ell_pkg::ST_READ;
            end
            ell_pkg::FN_TICK: state_next = ell_pkg::ST_TICK;
            ell_pkg::FN_ARM: begin
              cmd.arm    = 1'b1;
              state_next = ell_pkg::ST_DONE;
            end
            default: state_next = ell_pkg::ST_DONE;
          endcase
        end
      end
      ell_pkg::ST_READ: begin
        cmd.zero_wr = 1'b1;
        state_next  = ell_pkg::ST_MAC;
      end
      ell_pkg::ST_MAC: begin
        cmd.mac    = 1'b1;
        state_next = ell_pkg::ST_MUL;
      end
      ell_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ell_pkg::ST_LIMIT;
      end
      ell_pkg::ST_LIMIT: begin
        cmd.lim    = 1'b1;
        state_next = ell_pkg::ST_DONE;
      end
      ell_pkg::ST_TICK: begin
        cmd.tick   = 1'b1;
        state_next = ell_pkg::ST_DONE;
      end
      ell_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ell_pkg::ST_IDLE;
        end
      end
      default: state_next = ell_pkg::ST_CLEAR;
    endcase
  end

  // only one source may drive the RAM write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.zero_wr, cmd.lim}))
    else $error("ell_ctrl: RAM write conflict");

  // a request is never taken while the previous one is still in flight
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !cmd.take)
    else $error("ell_ctrl: request taken twice in a row");

endmodule

>>> rtl/ell_dpath.sv
// ----------------------------------------------------------------------------
// ell_dpath
// Ring positions, skip run, echo MAC, limiter multiply/saturate, gain update
// and the result register.
// ----------------------------------------------------------------------------
module ell_dpath #(
  parameter int RING_DEPTH = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  ell_pkg::ell_cmd_t  cmd,
  output ell_pkg::ell_stat_t stat,
  input  ell_pkg::ell_cfg_t  cfg,
  input  ell_pkg::ell_in_t   req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ell_pkg::ell_out_t  rsp_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = (AW + 1 > 16) ? AW + 1 : 16;
  localparam int SW = ell_pkg::SUM_W;
  localparam int PW = ell_pkg::PROD_W;
  localparam logic signed [PW-1:0] Q_MAX   = 32767;
  localparam logic signed [PW-1:0] Q_MIN   = -32768;
  localparam logic signed [PW-1:0] RND_ADJ = (1 <<< ell_pkg::FRAC_SHIFT) - 1;

  ell_pkg::ell_func_t op;
  logic signed [15:0] smp;
  logic [AW-1:0]      wp, rp, clr_addr;
  logic [15:0]        skip_left;
  logic [14:0]        skip_wait;
  logic               byp, zero;
  logic signed [SW-1:0] sum;
  logic signed [PW-1:0] prod;
  logic signed [15:0] res;
  logic [31:0]        dec_prod, tick_prod;
  logic               dec_en;
  logic [15:0]        gain;

  // ring position step
  logic [LW-1:0] len, wp_inc, wp_n, rp_inc, rp_n;
  logic          hit, do_zero;
  logic [14:0]   wait_eff;

  always_comb begin
    len = (LW'(cfg.loop_length) > LW'(RING_DEPTH)) ? LW'(RING_DEPTH)
                                                   : LW'(cfg.loop_length);
    wp_inc   = LW'(wp) + 1'b1;
    wp_n     = (wp_inc >= len) ? '0 : wp_inc;
    rp_inc   = wp_n + 1'b1;
    rp_n     = (rp_inc >= len) ? '0 : rp_inc;
    hit      = (skip_wait != '0) && (LW'(skip_wait) == rp_n);
    wait_eff = hit ? '0 : skip_wait;
    do_zero  = (skip_left != '0) && (wait_eff == '0);
  end

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata, ram_q;
  logic signed [15:0] sat;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    priority if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.zero_wr && zero) begin
      ram_we    = 1'b1;
      ram_waddr = rp;
    end else if (cmd.lim) begin
      ram_we    = 1'b1;
      ram_waddr = wp;
      ram_wdata = sat;
    end
  end

  ell_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_q)
  );

  // arithmetic
  logic signed [15:0]   ent;
  logic signed [9:0]    eg_s;
  logic signed [16:0]   gain_s;
  logic signed [SW-1:0] mac_term;
  logic signed [PW-1:0] prod_term, lim, q;
  logic                 over;
  logic [17:0]          rec;
  logic [15:0]          gain_new;

  always_comb begin
    ent       = (byp || zero) ? 16'sd0 : signed'(ram_q);
    eg_s      = signed'({1'b0, cfg.echo_gain});
    gain_s    = signed'({1'b0, gain});
    mac_term  = ent * eg_s;
    prod_term = sum * gain_s;
    lim       = signed'({6'b0, cfg.limiter_threshold, 22'b0});
    over      = (prod > lim) || (prod < -lim);
    // truncate toward zero
    q         = (prod < 0) ? ((prod + RND_ADJ) >>> ell_pkg::FRAC_SHIFT)
                           : (prod >>> ell_pkg::FRAC_SHIFT);
    priority if (q > Q_MAX) begin
      sat = 16'sd32767;
    end else if (q < Q_MIN) begin
      sat = -16'sd32768;
    end else begin
      sat = q[15:0];
    end
    rec      = tick_prod[31:14];
    gain_new = gain;
    if (op == ell_pkg::FN_SAMPLE && dec_en) begin
      gain_new = dec_prod[31:16];
    end else if (op == ell_pkg::FN_TICK && gain < cfg.limiter_ceiling) begin
      gain_new = (rec > {2'b0, cfg.limiter_ceiling}) ? cfg.limiter_ceiling
                                                     : rec[15:0];
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      skip_left <= '0;
      skip_wait <= '0;
      clr_addr  <= '0;
      zero      <= 1'b0;
      dec_en    <= 1'b0;
      gain      <= ell_pkg::RST_LIMITER_GAIN;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.take) begin
        zero   <= 1'b0;
        dec_en <= 1'b0;
      end
      if (cmd.step && cfg.loop_length != '0) begin
        wp <= wp_n[AW-1:0];
        rp <= rp_n[AW-1:0];
        if (skip_left != '0) begin
          skip_wait <= wait_eff;
        end
        if (do_zero) begin
          zero      <= 1'b1;
          skip_left <= skip_left - 1'b1;
        end
      end
      if (cmd.arm) begin
        skip_left <= req_data.skip_count;
        skip_wait <= req_data.skip_start;
      end
      if (cmd.lim) begin
        dec_en <= over && (gain >= ell_pkg::GAIN_FLOOR);
      end
      if (cmd.emit) begin
        gain      <= gain_new;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op  <= req_data.func;
      smp <= req_data.sample_in;
      byp <= (cfg.loop_length == '0);
      res <= '0;
    end
    if (cmd.mac) begin
      sum <= (SW'(smp) <<< 8) + mac_term;
    end
    if (cmd.mul) begin
      prod <= prod_term;
    end
    if (cmd.lim) begin
      res      <= sat;
      dec_prod <= gain * cfg.limiter_decay;
    end
    if (cmd.tick) begin
      tick_prod <= gain * cfg.limiter_recover;
    end
    if (cmd.emit) begin
      rsp_data.sample_out <= res;
      rsp_data.gain_now   <= gain_new;
    end
  end

  always_comb begin
    stat.clear_last = (clr_addr == AW'(RING_DEPTH - 1));
    stat.out_busy   = rsp_valid && rsp_stall;
  end

  // after a step the write position lies inside the loop
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && cfg.loop_length != '0) |=> (LW'(wp) < $past(len)))
    else $error("ell_dpath: write position outside loop");

  // a skip run counts down by at most one per sample
  a_skip_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !cmd.arm) |=>
      (skip_left == $past(skip_left)) || (skip_left == $past(skip_left) - 16'd1))
    else $error("ell_dpath: skip run count jumped");

endmodule

>>> rtl/echo_loop_with_dynamic_limiter.sv
// ----------------------------------------------------------------------------
// echo_loop_with_dynamic_limiter
// Looping echo ring with feedback gain and a dynamic output limiter.
// ----------------------------------------------------------------------------
//  channel  | signals                               | dir | flow
//  ---------+---------------------------------------+-----+----------------
//  req      | req_valid, req_stall, req_data        | in  | valid / stall
//  rsp      | rsp_valid, rsp_stall, rsp_data        | out | valid / stall
//  cfg      | cfg_valid, cfg_ready, cfg_index/data  | in  | valid / ready
//
//  After reset a clearing pass zeroes every ring address; requests are
//  stalled meanwhile (cfg writes are taken).
//  Sample request: RAM read, then the two registered multiplies (echo MAC,
//  limiter gain), then limit/write-back and result, in one shared datapath.
//  Recovery tick: recovery multiply, then result; arm, unused code: result only.
//  A stalled result holds in the output register; the next request is taken
//  meanwhile and waits in its last step for the register to free up.
// ----------------------------------------------------------------------------
module echo_loop_with_dynamic_limiter #(
  parameter int RING_DEPTH = 32768
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  ell_pkg::ell_in_t                   req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output ell_pkg::ell_out_t                  rsp_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ell_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);

  ell_pkg::ell_cfg_t  cfg;
  ell_pkg::ell_cmd_t  cmd;
  ell_pkg::ell_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_length       <= ell_pkg::RST_LOOP_LENGTH;
      cfg.echo_gain         <= ell_pkg::RST_ECHO_GAIN;
      cfg.limiter_threshold <= ell_pkg::RST_LIMITER_THRESHOLD;
      cfg.limiter_decay     <= ell_pkg::RST_LIMITER_DECAY;
      cfg.limiter_recover   <= ell_pkg::RST_LIMITER_RECOVER;
      cfg.limiter_ceiling   <= ell_pkg::RST_LIMITER_CEILING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ell_pkg::REG_LOOP_LENGTH:       cfg.loop_length       <= cfg_data;
        ell_pkg::REG_ECHO_GAIN:         cfg.echo_gain         <= cfg_data[8:0];
        ell_pkg::REG_LIMITER_THRESHOLD: cfg.limiter_threshold <= cfg_data[14:0];
        ell_pkg::REG_LIMITER_DECAY:     cfg.limiter_decay     <= cfg_data;
        ell_pkg::REG_LIMITER_RECOVER:   cfg.limiter_recover   <= cfg_data;
        ell_pkg::REG_LIMITER_CEILING:   cfg.limiter_ceiling   <= cfg_data;
        default: ;
      endcase
    end
  end

  ell_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req_data.func),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ell_dpath #(.RING_DEPTH(RING_DEPTH)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
